// ----- rtl/lkv_pkg.sv -----
// Shared types and constants for the LRU key/value cache.
// No dependencies; used by every file in rtl/.
`default_nettype none

package lkv_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_W          = 32;
  localparam int VAL_W          = 32;
  localparam int ACTIVE_W       = 5;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_WRITE  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } lkv_entry_t;

  // Broadcast from the top level to every cell in the update cycle.
  typedef struct packed {
    logic go;     // apply the request this cycle
    logic hit;    // key found in some cell
    logic write;  // request is a write
    logic fill;   // room left below the active capacity
  } lkv_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/lkv_cell.sv -----
// One recency position of the LRU chain: holds an entry and its valid bit.
// Depends on lkv_pkg. Cell 0 is most recent; a shift pulls from the lower neighbor.
`default_nettype none

module lkv_cell (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire lkv_pkg::lkv_ctl_t                ctl,
  input  wire logic signed [lkv_pkg::KEY_W-1:0] req_key,
  input  wire lkv_pkg::lkv_entry_t              prev_entry,
  input  wire logic                             prev_valid,
  input  wire logic                             seen_in,
  input  wire logic signed [lkv_pkg::VAL_W-1:0] acc_in,
  output lkv_pkg::lkv_entry_t                   entry,
  output logic                                  valid,
  output logic                                  seen_out,
  output logic signed [lkv_pkg::VAL_W-1:0]      acc_out
);

  logic match;
  logic shift;

  assign match    = valid && (entry.key == req_key);
  assign seen_out = seen_in | match;
  assign acc_out  = acc_in | (match ? entry.value : '0);

  // On a hit, every cell up to and including the hit position moves down one.
  // On a write miss, valid cells move down (the last one drops out when full).
  always_comb begin
    if (ctl.hit) begin
      shift = ctl.go && !seen_in;
    end else begin
      shift = ctl.go && ctl.write && (ctl.fill ? prev_valid : valid);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= prev_entry;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lru_key_value_cache_unit.sv -----
// Top level of the LRU key/value cache: request/result handshakes, capacity
// register and the chain of lkv_cell recency cells. Depends on lkv_pkg, lkv_cell.
//
// Usage:
//   Request channel: in_valid/in_stall with opcode, key, value. opcode is a
//   lookup or a write. A request is taken when in_valid is high and in_stall low.
//   Result channel: out_valid/out_stall with hit and read_value. hit tells if
//   the key was present before the request; read_value carries the stored
//   value on a lookup hit and zero otherwise.
//   Config: cfg_wen writes cfg_wdata into the capacity register (0 acts as 1,
//   values above ENTRIES act as ENTRIES). Write it only while idle.
//   Timing: one request at a time. A request is registered, then compared
//   against all cells and applied, and its result lands in the output register.
//   The next request is taken only once the current one has been applied.
//   Each request is handled by a single compare-and-shift pass over the cell chain.
//   If the result is stalled, the pending request waits in the update stage and
//   in_stall stays high until the output register frees up.
//   Reset: all entries invalid, capacity ENTRIES_DEF, no result pending.
`default_nettype none

module lru_key_value_cache_unit #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                opcode,
  input  wire logic signed [lkv_pkg::KEY_W-1:0]    key,
  input  wire logic signed [lkv_pkg::VAL_W-1:0]    value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     hit,
  output logic signed [lkv_pkg::VAL_W-1:0]         read_value,
  input  wire logic                                cfg_wen,
  input  wire logic [lkv_pkg::ACTIVE_W-1:0]        cfg_wdata
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lkv_pkg::ACTIVE_W) ? CNT_W : lkv_pkg::ACTIVE_W;

  logic [lkv_pkg::ACTIVE_W-1:0]         active_entries;
  logic [CNT_W-1:0]                     filled_count;
  logic                                 busy;
  lkv_pkg::opcode_t                     req_op;
  logic signed [lkv_pkg::KEY_W-1:0]     req_key;
  logic signed [lkv_pkg::VAL_W-1:0]     req_value;

  logic [CMP_W-1:0]                     cap;
  logic [CMP_W-1:0]                     active_ext;
  logic                                 out_free;
  lkv_pkg::lkv_ctl_t                    ctl;

  lkv_pkg::lkv_entry_t                  link   [0:ENTRIES];
  logic                                 vlink  [0:ENTRIES];
  logic                                 seen   [0:ENTRIES];
  logic signed [lkv_pkg::VAL_W-1:0]     acc    [0:ENTRIES];

  assign in_stall = busy;
  assign out_free = !out_valid || !out_stall;

  assign active_ext = CMP_W'(active_entries);

  always_comb begin
    if (active_entries == '0) begin
      cap = CMP_W'(1);
    end else if (active_ext > CMP_W'(ENTRIES)) begin
      cap = CMP_W'(ENTRIES);
    end else begin
      cap = active_ext;
    end
  end

  assign ctl.go    = busy && out_free;
  assign ctl.hit   = seen[ENTRIES];
  assign ctl.write = (req_op == lkv_pkg::OP_WRITE);
  assign ctl.fill  = CMP_W'(filled_count) < cap;

  // New most-recent entry enters at the head of the chain.
  assign link[0].key   = req_key;
  assign link[0].value = (ctl.hit && !ctl.write) ? acc[ENTRIES] : req_value;
  assign vlink[0]      = 1'b1;
  assign seen[0]       = 1'b0;
  assign acc[0]        = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .req_key    (req_key),
      .prev_entry (link[i]),
      .prev_valid (vlink[i]),
      .seen_in    (seen[i]),
      .acc_in     (acc[i]),
      .entry      (link[i+1]),
      .valid      (vlink[i+1]),
      .seen_out   (seen[i+1]),
      .acc_out    (acc[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= lkv_pkg::ACTIVE_RESET;
    end else if (cfg_wen) begin
      active_entries <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      out_valid    <= 1'b0;
      filled_count <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        busy <= 1'b1;
      end else if (ctl.go) begin
        busy <= 1'b0;
      end

      if (ctl.go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (ctl.go && ctl.write && !ctl.hit && ctl.fill) begin
        filled_count <= filled_count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_op    <= lkv_pkg::opcode_t'(opcode);
      req_key   <= key;
      req_value <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.go) begin
      hit        <= ctl.hit;
      read_value <= ctl.write ? '0 : acc[ENTRIES];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lkv_checker.sv -----
// Port-level checks for lru_key_value_cache_unit, bound to the top level.
// Depends on lkv_pkg for field widths.
`default_nettype none

module lkv_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire logic                             hit,
  input wire logic signed [lkv_pkg::VAL_W-1:0] read_value
);

  // A stalled result stays up.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // One request in flight: the block is busy right after taking a request.
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // A new result only follows a request that was being worked on.
  a_rose_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a pending request");

  // Misses never carry data.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> read_value == '0)
    else $error("nonzero read_value on a miss");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hit        (hit),
  .read_value (read_value)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache_unit: an LRU model predicts every result.
// Depends on lkv_pkg and the lru_key_value_cache_unit RTL.

module testbench;
  import lkv_pkg::*;

  localparam int CACHE_SLOTS  = ENTRIES_DEF;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTED = 10;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } cache_reply_t;

  logic                    clk;
  logic                    rst        = 1'b1;
  logic                    in_valid   = 1'b0;
  logic                    opcode     = OP_LOOKUP;
  logic signed [KEY_W-1:0] key        = '0;
  logic signed [VAL_W-1:0] value      = '0;
  logic                    out_stall  = 1'b0;
  logic                    cfg_wen    = 1'b0;
  logic [ACTIVE_W-1:0]     cfg_wdata  = '0;
  wire                     in_stall;
  wire                     out_valid;
  wire                     hit;
  wire signed [VAL_W-1:0]  read_value;

  // Shadow copy of the cache contents
  logic [KEY_W-1:0]    shadow_keys   [CACHE_SLOTS];
  logic [VAL_W-1:0]    shadow_values [CACHE_SLOTS];
  logic [3:0]          shadow_rank   [CACHE_SLOTS];
  logic                shadow_valid  [CACHE_SLOTS];
  int                  shadow_filled = 0;
  logic [ACTIVE_W-1:0] shadow_capacity = ACTIVE_RESET;

  cache_reply_t expected_replies[$];
  int errors        = 0;
  int reply_count   = 0;
  int idle_cycles   = 0;
  int max_gap       = 15;
  int max_stall     = 15;
  int stall_left    = 0;

  lru_key_value_cache_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .key        (key),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hit        (hit),
    .read_value (read_value),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      shadow_keys[i]   = '0;
      shadow_values[i] = '0;
      shadow_rank[i]   = '0;
      shadow_valid[i]  = 1'b0;
    end
  end

  // Move slot s to most recent; entries more recent than it age by one.
  function automatic void make_most_recent(int s);
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (shadow_valid[i] && i != s && shadow_rank[i] < shadow_rank[s])
        shadow_rank[i] = shadow_rank[i] + 4'd1;
    end
    shadow_rank[s] = '0;
  endfunction

  function automatic cache_reply_t predict_cache_access(opcode_t op, logic [KEY_W-1:0] k,
                                                        logic [VAL_W-1:0] v);
    cache_reply_t r;
    int cap;
    int found;
    int victim;
    logic [3:0] worst;
    cap = int'(shadow_capacity);
    if (cap == 0) cap = 1;
    if (cap > CACHE_SLOTS) cap = CACHE_SLOTS;
    found = -1;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (shadow_valid[i] && shadow_keys[i] == k) begin
        found = i;
        break;
      end
    end
    r.hit = (found >= 0);
    r.read_value = '0;
    if (found >= 0) begin
      make_most_recent(found);
      if (op == OP_LOOKUP) r.read_value = shadow_values[found];
      else shadow_values[found] = v;
      return r;
    end
    if (op == OP_LOOKUP) return r;
    if (shadow_filled < cap) begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
        if (!shadow_valid[i]) begin
          for (int j = 0; j < CACHE_SLOTS; j++)
            if (shadow_valid[j]) shadow_rank[j] = shadow_rank[j] + 4'd1;
          shadow_valid[i]  = 1'b1;
          shadow_keys[i]   = k;
          shadow_values[i] = v;
          shadow_rank[i]   = '0;
          shadow_filled++;
          return r;
        end
      end
    end
    // full (or shrunk below fill): replace the oldest, first slot wins a tie
    victim = -1;
    worst  = '0;
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > worst)) begin
        victim = i;
        worst  = shadow_rank[i];
      end
    end
    if (victim >= 0) begin
      make_most_recent(victim);
      shadow_keys[victim]   = k;
      shadow_values[victim] = v;
    end
    return r;
  endfunction

  // Valid is left high after acceptance; the next call either lowers it or
  // presents the next request in the same time step.
  task automatic send_request(opcode_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
    expected_replies.push_back(predict_cache_access(op, k, v));
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_capacity(logic [ACTIVE_W-1:0] n);
    wait_until_idle();
    cfg_wen   <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_wen <= 1'b0;
    shadow_capacity = n;
  endtask

  task automatic test_request_extremes();
    send_request(OP_LOOKUP, 32'h0000_0000, 32'h1234_5678);
    send_request(OP_WRITE,  32'h8000_0000, 32'h7fff_ffff);
    send_request(OP_WRITE,  32'h7fff_ffff, 32'h8000_0000);
    send_request(OP_WRITE,  32'hffff_ffff, 32'h0000_0000);
    send_request(OP_WRITE,  32'h0000_0000, 32'hffff_ffff);
    send_request(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
    send_request(OP_LOOKUP, 32'h7fff_ffff, 32'hffff_ffff);
    send_request(OP_LOOKUP, 32'hffff_ffff, 32'h5555_5555);
    send_request(OP_WRITE,  32'h0000_0000, 32'h5a5a_a5a5);
    send_request(OP_LOOKUP, 32'h0000_0000, 32'haaaa_aaaa);
    send_request(OP_LOOKUP, 32'h0000_0001, 32'h0000_0000);
  endtask

  // Zero capacity acts as one; a value above the array acts as the array size.
  task automatic test_capacity_extremes();
    set_capacity(5'd0);
    send_request(OP_WRITE,  32'd5, 32'hcafe_0005);
    send_request(OP_LOOKUP, 32'd5, 32'h0);
    send_request(OP_WRITE,  32'd6, 32'hcafe_0006);
    send_request(OP_LOOKUP, 32'd5, 32'h0);
    send_request(OP_LOOKUP, 32'd6, 32'h0);
    set_capacity(5'd31);
    send_request(OP_WRITE,  32'd7, 32'hcafe_0007);
    send_request(OP_LOOKUP, 32'd6, 32'h0);
    send_request(OP_LOOKUP, 32'd7, 32'h0);
  endtask

  task automatic run_traffic_phase(int n_items, int pool_n);
    logic [KEY_W-1:0] pool [40];
    logic [KEY_W-1:0] k;
    opcode_t op;
    for (int i = 0; i < pool_n; i++) pool[i] = $urandom;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 4) == 0) k = $urandom;
      else k = pool[$urandom_range(0, pool_n - 1)];
      op = ($urandom_range(0, 1) == 0) ? OP_LOOKUP : OP_WRITE;
      send_request(op, k, $urandom);
    end
  endtask

  // Phase order also shrinks the capacity below the current fill level.
  task automatic test_random_traffic();
    logic [ACTIVE_W-1:0] caps [10] = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31,
                                       5'd17, 5'd8, 5'd2, 5'd16, 5'd12};
    int eff;
    for (int p = 0; p < 10; p++) begin
      set_capacity(caps[p]);
      eff = int'(caps[p]);
      if (eff == 0) eff = 1;
      if (eff > CACHE_SLOTS) eff = CACHE_SLOTS;
      case ($urandom_range(0, 3))
        0: begin max_gap = 15; max_stall = 15; end
        1: begin max_gap = 0;  max_stall = 15; end
        2: begin max_gap = 15; max_stall = 0;  end
        default: begin max_gap = 0; max_stall = 0; end
      endcase
      run_traffic_phase(173, eff + $urandom_range(1, eff + 2));
    end
    max_gap   = 15;
    max_stall = 15;
  endtask

  // Result side: check each accepted reply, then hold stall for a random count.
  always @(posedge clk) begin
    cache_reply_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        reply_count++;
        if (expected_replies.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTED)
            $display("reply %0d: unexpected, hit %0b read_value %h",
                     reply_count, hit, read_value);
        end else begin
          exp_r = expected_replies.pop_front();
          if (hit !== exp_r.hit || read_value !== exp_r.read_value) begin
            errors++;
            if (errors <= MAX_REPORTED)
              $display("reply %0d: hit exp %0b got %0b, read_value exp %h got %h",
                       reply_count, exp_r.hit, hit, exp_r.read_value, read_value);
          end
        end
        stall_left = $urandom_range(0, max_stall);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("** lru_key_value_cache_unit: FAILED **");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_request_extremes();
    test_capacity_extremes();
    test_random_traffic();
    wait_until_idle();
    repeat (4) @(posedge clk);
    errors += expected_replies.size();
    if (errors == 0)
      $display("** lru_key_value_cache_unit: PASSED **");
    else
      $display("** lru_key_value_cache_unit: FAILED **");
    $finish;
  end

endmodule
